### src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared types and arithmetic for the ping-pong stereo delay
// Sample and gain widths, beat structs, register indexes and the fixed-point
// helpers used by both the delay lanes and the output mixer.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Line depth must be a power of two: the read address wraps by truncation.
  localparam int LINE_DEPTH  = 65536;
  localparam int ADDR_BITS   = $clog2(LINE_DEPTH);
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 9;
  localparam int GAIN_SHIFT  = 8;
  localparam int DELAY_BITS  = 16;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int QUOT_BITS   = PROD_BITS - GAIN_SHIFT;
  localparam int SUM_BITS    = QUOT_BITS + 1;

  localparam logic [GAIN_BITS-1:0]   GAIN_UNITY = GAIN_BITS'(1 << GAIN_SHIFT);
  localparam logic [PROD_BITS-1:0]   ROUND_BIAS = PROD_BITS'((1 << GAIN_SHIFT) - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration register indexes
  localparam int REG_INDEX_BITS = 2;
  localparam logic [REG_INDEX_BITS-1:0] REG_DELAY    = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_FEEDBACK = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_WET      = 2'd2;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd24000;
  localparam logic [GAIN_BITS-1:0]  FB_RESET    = 9'd128;
  localparam logic [GAIN_BITS-1:0]  WET_RESET   = 9'd128;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_beat_t;

  // Lane control, shared by both channels
  typedef struct packed {
    logic rd_en;    // beat accepted: read the line
    logic rd_live;  // read entry has been written since reset
    logic fwd;      // read entry is being written this same edge
    logic wr_en;    // lane stage advances: commit its store value
  } lane_ctl_t;

  function automatic logic [GAIN_BITS-1:0] sat_gain(input logic [GAIN_BITS-1:0] g);
    return (g > GAIN_UNITY) ? GAIN_UNITY : g;
  endfunction

  function automatic logic signed [PROD_BITS-1:0] gain_mul(
    input logic signed [SAMPLE_BITS-1:0] s,
    input logic        [GAIN_BITS-1:0]   g
  );
    return PROD_BITS'(s) * PROD_BITS'($signed({1'b0, g}));
  endfunction

  // Divide by 256, truncating toward zero
  function automatic logic signed [QUOT_BITS-1:0] div_unity(
    input logic signed [PROD_BITS-1:0] p
  );
    logic [PROD_BITS-1:0] adj;
    adj = p[PROD_BITS-1] ? (p + ROUND_BIAS) : p;
    return $signed(adj[PROD_BITS-1:GAIN_SHIFT]);
  endfunction

  function automatic logic signed [SUM_BITS-1:0] widen(
    input logic signed [SAMPLE_BITS-1:0] s
  );
    return $signed({{(SUM_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s});
  endfunction

  function automatic logic signed [SUM_BITS-1:0] widen_q(
    input logic signed [QUOT_BITS-1:0] q
  );
    return $signed({q[QUOT_BITS-1], q});
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
    input logic signed [SUM_BITS-1:0] v
  );
    logic [SUM_BITS-SAMPLE_BITS:0] top;
    top = v[SUM_BITS-1:SAMPLE_BITS-1];
    if (top == '0 || top == '1) begin
      return v[SAMPLE_BITS-1:0];
    end
    return v[SUM_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
  endfunction

endpackage

### src/psd_lane.sv
// ----------------------------------------------------------------------------
// psd_lane: one channel's delay line
// Reads the line on the accept edge, resolves unwritten entries and a write
// landing on the same edge, then builds the feedback sum from the other
// channel's delayed sample and commits it at the write pointer.
// ----------------------------------------------------------------------------
module psd_lane (
  input  logic                                 clk,
  input  psd_pkg::lane_ctl_t                   ctl,
  input  logic [psd_pkg::ADDR_BITS-1:0]        rd_addr,
  input  logic [psd_pkg::ADDR_BITS-1:0]        wr_addr,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] x_in,
  input  logic [psd_pkg::GAIN_BITS-1:0]        fb_gain,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] other_dly,
  output logic signed [psd_pkg::SAMPLE_BITS-1:0] dly,
  output logic signed [psd_pkg::SAMPLE_BITS-1:0] x_held
);

  logic [psd_pkg::SAMPLE_BITS-1:0]        line_mem [psd_pkg::LINE_DEPTH];
  logic [psd_pkg::SAMPLE_BITS-1:0]        rd_data;
  logic                                   live;
  logic                                   fwd;
  logic signed [psd_pkg::SAMPLE_BITS-1:0] fwd_data;
  logic signed [psd_pkg::SAMPLE_BITS-1:0] x_reg;
  logic signed [psd_pkg::SAMPLE_BITS-1:0] store;
  logic signed [psd_pkg::SUM_BITS-1:0]    fb_sum;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      line_mem[wr_addr] <= store;
    end
    if (ctl.rd_en) begin
      rd_data <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      live     <= ctl.rd_live;
      fwd      <= ctl.fwd;
      fwd_data <= store;
      x_reg    <= x_in;
    end
  end

  // A never-written entry reads as silence
  always_comb begin
    if (fwd) begin
      dly = fwd_data;
    end else if (live) begin
      dly = $signed(rd_data);
    end else begin
      dly = '0;
    end
  end

  assign fb_sum = psd_pkg::widen(x_reg)
                + psd_pkg::widen_q(psd_pkg::div_unity(psd_pkg::gain_mul(other_dly, fb_gain)));
  assign store  = psd_pkg::clamp_sample(fb_sum);
  assign x_held = x_reg;

endmodule

### src/psd_mix.sv
// ----------------------------------------------------------------------------
// psd_mix: wet/dry merge and output register
// Registers the wet and dry products of both lanes, then scales, sums and
// clamps them into the output register.
// ----------------------------------------------------------------------------
module psd_mix (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_go,
  output logic                                   take_ready,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] dly_l,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] dly_r,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] x_l,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] x_r,
  input  logic [psd_pkg::GAIN_BITS-1:0]          wet_gain,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output psd_pkg::out_beat_t                     out_data
);

  logic [psd_pkg::GAIN_BITS-1:0]        dry_gain;
  logic                                 prod_valid;
  logic                                 prod_valid_next;
  logic                                 out_valid_next;
  logic                                 out_go;
  logic                                 prod_go;
  logic signed [psd_pkg::PROD_BITS-1:0] wet_l;
  logic signed [psd_pkg::PROD_BITS-1:0] wet_r;
  logic signed [psd_pkg::PROD_BITS-1:0] dry_l;
  logic signed [psd_pkg::PROD_BITS-1:0] dry_r;
  logic signed [psd_pkg::SUM_BITS-1:0]  sum_l;
  logic signed [psd_pkg::SUM_BITS-1:0]  sum_r;

  assign dry_gain   = psd_pkg::GAIN_UNITY - wet_gain;
  assign out_go     = !out_valid || out_ready;
  assign take_ready = !prod_valid || out_go;
  assign prod_go    = prod_valid && out_go;

  always_comb begin
    prod_valid_next = prod_valid;
    if (in_go) begin
      prod_valid_next = 1'b1;
    end else if (prod_go) begin
      prod_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (prod_go) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= prod_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      wet_l <= psd_pkg::gain_mul(dly_l, wet_gain);
      wet_r <= psd_pkg::gain_mul(dly_r, wet_gain);
      dry_l <= psd_pkg::gain_mul(x_l, dry_gain);
      dry_r <= psd_pkg::gain_mul(x_r, dry_gain);
    end
  end

  assign sum_l = psd_pkg::widen_q(psd_pkg::div_unity(wet_l))
               + psd_pkg::widen_q(psd_pkg::div_unity(dry_l));
  assign sum_r = psd_pkg::widen_q(psd_pkg::div_unity(wet_r))
               + psd_pkg::widen_q(psd_pkg::div_unity(dry_r));

  always_ff @(posedge clk) begin
    if (prod_go) begin
      out_data.left_out  <= psd_pkg::clamp_sample(sum_l);
      out_data.right_out <= psd_pkg::clamp_sample(sum_r);
    end
  end

endmodule

### src/ping_pong_stereo_delay.sv
// ----------------------------------------------------------------------------
// ping_pong_stereo_delay: stereo delay with cross-channel feedback
// Two delay lanes read at write pointer minus delay, feed each other's delayed
// sample back into their own line, and a mixer blends wet and dry signals.
//
//   channel   signals                           beat
//   input     in_valid / in_ready / in_data     one stereo pair
//   output    out_valid / out_ready / out_data  one mixed stereo pair
//   config    write_en / reg_index / write_data one register write
//
// One stereo pair per cycle while the output is not stalled; a taken beat passes
// the line read, the product register and the output register in turn.
// The feedback loop closes in the lane stage: a write landing on the address
// being read is forwarded, so a delay of one runs at full rate.
// After reset the lines read as zero by tracking how far the write pointer
// has run; there is no clearing pass and input is taken at once.
// Each stage holds only while the one after it is full and stalled.
// ----------------------------------------------------------------------------
module ping_pong_stereo_delay (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  psd_pkg::in_beat_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output psd_pkg::out_beat_t                    out_data,
  input  logic                                  write_en,
  input  logic [psd_pkg::REG_INDEX_BITS-1:0]    reg_index,
  input  logic [psd_pkg::DELAY_BITS-1:0]        write_data
);

  logic [psd_pkg::DELAY_BITS-1:0] delay_length;
  logic [psd_pkg::GAIN_BITS-1:0]  feedback_amount;
  logic [psd_pkg::GAIN_BITS-1:0]  wet_amount;
  logic [psd_pkg::GAIN_BITS-1:0]  fb_gain;
  logic [psd_pkg::GAIN_BITS-1:0]  wet_gain;

  logic [psd_pkg::ADDR_BITS-1:0]  wp;
  logic [psd_pkg::ADDR_BITS-1:0]  rp;
  logic [psd_pkg::ADDR_BITS-1:0]  lane_wp;
  logic                           wrapped;
  logic                           lane_valid;
  logic                           lane_valid_next;
  logic                           in_go;
  logic                           lane_go;
  logic                           mix_ready;
  psd_pkg::lane_ctl_t             ctl;

  logic signed [psd_pkg::SAMPLE_BITS-1:0] dly_l;
  logic signed [psd_pkg::SAMPLE_BITS-1:0] dly_r;
  logic signed [psd_pkg::SAMPLE_BITS-1:0] x_l;
  logic signed [psd_pkg::SAMPLE_BITS-1:0] x_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length    <= psd_pkg::DELAY_RESET;
      feedback_amount <= psd_pkg::FB_RESET;
      wet_amount      <= psd_pkg::WET_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        psd_pkg::REG_DELAY:    delay_length    <= write_data;
        psd_pkg::REG_FEEDBACK: feedback_amount <= write_data[psd_pkg::GAIN_BITS-1:0];
        psd_pkg::REG_WET:      wet_amount      <= write_data[psd_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign fb_gain  = psd_pkg::sat_gain(feedback_amount);
  assign wet_gain = psd_pkg::sat_gain(wet_amount);

  // Handshake and pointer control
  assign in_ready = !lane_valid || mix_ready;
  assign in_go    = in_valid && in_ready;
  assign lane_go  = lane_valid && mix_ready;
  assign rp       = wp - psd_pkg::ADDR_BITS'(delay_length);

  assign ctl.rd_en   = in_go;
  assign ctl.rd_live = wrapped || (rp < wp);
  assign ctl.fwd     = in_go && lane_go && (lane_wp == rp);
  assign ctl.wr_en   = lane_go;

  always_comb begin
    lane_valid_next = lane_valid;
    if (in_go) begin
      lane_valid_next = 1'b1;
    end else if (lane_go) begin
      lane_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      wp         <= '0;
      wrapped    <= 1'b0;
    end else begin
      lane_valid <= lane_valid_next;
      if (in_go) begin
        wp <= wp + 1'b1;
        if (wp == '1) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      lane_wp <= wp;
    end
  end

  psd_lane u_lane_l (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rp),
    .wr_addr   (lane_wp),
    .x_in      (in_data.left_in),
    .fb_gain   (fb_gain),
    .other_dly (dly_r),
    .dly       (dly_l),
    .x_held    (x_l)
  );

  psd_lane u_lane_r (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rp),
    .wr_addr   (lane_wp),
    .x_in      (in_data.right_in),
    .fb_gain   (fb_gain),
    .other_dly (dly_l),
    .dly       (dly_r),
    .x_held    (x_r)
  );

  psd_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .in_go      (lane_go),
    .take_ready (mix_ready),
    .dly_l      (dly_l),
    .dly_r      (dly_r),
    .x_l        (x_l),
    .x_r        (x_r),
    .wet_gain   (wet_gain),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Checks
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !lane_valid |-> in_ready)
    else $error("input refused with the lane stage empty");

  a_fwd_on_write: assert property (@(posedge clk) disable iff (rst)
    ctl.fwd |-> (ctl.wr_en && ctl.rd_en))
    else $error("forward without a write and read on the same edge");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    in_go |=> (wp == psd_pkg::ADDR_BITS'($past(wp) + 1'b1)))
    else $error("write pointer did not advance by one beat");

  a_wrap_holds: assert property (@(posedge clk) disable iff (rst)
    wrapped |=> wrapped)
    else $error("wrap flag dropped outside reset");

endmodule

### sim/stereo_delay_checker.sv
// ----------------------------------------------------------------------------
// stereo_delay_checker: scoreboard for the ping-pong stereo delay
// Watches the register port and both beat channels. It keeps its own copy of
// the two delay lines and the settings, works out the mixed pair for every
// accepted input beat, and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module stereo_delay_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  psd_pkg::in_beat_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  psd_pkg::out_beat_t                  out_data,
  input  logic                                write_en,
  input  logic [psd_pkg::REG_INDEX_BITS-1:0]  reg_index,
  input  logic [psd_pkg::DELAY_BITS-1:0]      write_data,
  output int                                  mismatches,
  output int                                  backlog
);

  localparam longint UNITY  = longint'(1) << psd_pkg::GAIN_SHIFT;
  localparam longint TOP_HI = (longint'(1) << (psd_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint TOP_LO = -TOP_HI - 1;

  logic signed [psd_pkg::SAMPLE_BITS-1:0] left_tap  [0:psd_pkg::LINE_DEPTH-1];
  logic signed [psd_pkg::SAMPLE_BITS-1:0] right_tap [0:psd_pkg::LINE_DEPTH-1];
  logic [psd_pkg::ADDR_BITS-1:0]          head;
  logic [psd_pkg::DELAY_BITS-1:0]         delay_cfg;
  logic [psd_pkg::GAIN_BITS-1:0]          feedback_cfg;
  logic [psd_pkg::GAIN_BITS-1:0]          wet_cfg;
  psd_pkg::out_beat_t                     pending_mix [$];

  initial begin
    mismatches = 0;
    backlog    = 0;
  end

  function automatic logic signed [psd_pkg::SAMPLE_BITS-1:0] clip(input longint v);
    if (v > TOP_HI) return psd_pkg::SAMPLE_BITS'(TOP_HI);
    if (v < TOP_LO) return psd_pkg::SAMPLE_BITS'(TOP_LO);
    return psd_pkg::SAMPLE_BITS'(v);
  endfunction

  function automatic longint limit_gain(input logic [psd_pkg::GAIN_BITS-1:0] g);
    return (longint'(g) > UNITY) ? UNITY : longint'(g);
  endfunction

  // Read both lines at head minus delay, store the cross-fed sums, advance.
  function automatic psd_pkg::out_beat_t mix_next_pair(input psd_pkg::in_beat_t b);
    logic [psd_pkg::ADDR_BITS-1:0] tap;
    longint xl, xr, dl, dr, fb, wet, dry;
    psd_pkg::out_beat_t r;
    xl  = b.left_in;
    xr  = b.right_in;
    tap = head - psd_pkg::ADDR_BITS'(delay_cfg);
    dl  = left_tap[tap];
    dr  = right_tap[tap];
    fb  = limit_gain(feedback_cfg);
    wet = limit_gain(wet_cfg);
    dry = UNITY - wet;
    left_tap[head]  = clip(xl + (dr * fb) / UNITY);
    right_tap[head] = clip(xr + (dl * fb) / UNITY);
    r.left_out  = clip((dl * wet) / UNITY + (xl * dry) / UNITY);
    r.right_out = clip((dr * wet) / UNITY + (xr * dry) / UNITY);
    head = head + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    psd_pkg::out_beat_t want;
    if (rst) begin
      for (int i = 0; i < psd_pkg::LINE_DEPTH; i++) begin
        left_tap[i]  = '0;
        right_tap[i] = '0;
      end
      head         = '0;
      delay_cfg    = psd_pkg::DELAY_RESET;
      feedback_cfg = psd_pkg::FB_RESET;
      wet_cfg      = psd_pkg::WET_RESET;
      pending_mix.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_mix.size() == 0) begin
          $error("output beat with nothing expected: left_out %0d, right_out %0d",
                 out_data.left_out, out_data.right_out);
          mismatches++;
        end else begin
          want = pending_mix.pop_front();
          if (out_data.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
            mismatches++;
          end
          if (out_data.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, out_data.right_out);
            mismatches++;
          end
        end
      end
      if (write_en) begin
        case (reg_index)
          psd_pkg::REG_DELAY:    delay_cfg    = write_data;
          psd_pkg::REG_FEEDBACK: feedback_cfg = write_data[psd_pkg::GAIN_BITS-1:0];
          psd_pkg::REG_WET:      wet_cfg      = write_data[psd_pkg::GAIN_BITS-1:0];
          default: ;  // drop writes to unmapped indexes
        endcase
      end
      if (in_valid && in_ready) pending_mix.push_back(mix_next_pair(in_data));
    end
    backlog = pending_mix.size();
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the ping-pong stereo delay
// Drives stereo beats and register writes, with random idle bursts on both
// channels and one long output hold-off. A directed set covers the sample
// and gain extremes, zero and full-range delays; random phases follow with
// mostly short delays so the cross feedback builds up. Checking is done by
// the scoreboard alongside the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 120;
  localparam logic [psd_pkg::REG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  psd_pkg::in_beat_t                  in_data;
  logic                               out_valid;
  logic                               out_ready;
  psd_pkg::out_beat_t                 out_data;
  logic                               write_en;
  logic [psd_pkg::REG_INDEX_BITS-1:0] reg_index;
  logic [psd_pkg::DELAY_BITS-1:0]     write_data;
  int                                 mismatches;
  int                                 backlog;
  int                                 cycles;
  logic                               jitter;
  logic                               hold_long;

  ping_pong_stereo_delay DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .write_en(write_en), .reg_index(reg_index), .write_data(write_data)
  );

  stereo_delay_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .write_en(write_en), .reg_index(reg_index), .write_data(write_data),
    .mismatches(mismatches), .backlog(backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(negedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (jitter && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [psd_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return psd_pkg::SAMPLE_MAX;
      1:       return psd_pkg::SAMPLE_MIN;
      2:       return psd_pkg::SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
      default: return psd_pkg::SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic signed [psd_pkg::SAMPLE_BITS-1:0] smp(input int v);
    return psd_pkg::SAMPLE_BITS'(v);
  endfunction

  // Offer one beat and hold it until taken; returns on a falling edge.
  task automatic send_pair(input logic signed [psd_pkg::SAMPLE_BITS-1:0] l,
                           input logic signed [psd_pkg::SAMPLE_BITS-1:0] r);
    if (jitter && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data.left_in  <= l;
    in_data.right_in <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(input logic [psd_pkg::DELAY_BITS-1:0] d,
                              input logic [psd_pkg::DELAY_BITS-1:0] f,
                              input logic [psd_pkg::DELAY_BITS-1:0] w,
                              input logic                           poke_spare);
    write_en   <= 1'b1;
    reg_index  <= psd_pkg::REG_DELAY;
    write_data <= d;
    @(negedge clk);
    reg_index  <= psd_pkg::REG_FEEDBACK;
    write_data <= f;
    @(negedge clk);
    reg_index  <= psd_pkg::REG_WET;
    write_data <= w;
    @(negedge clk);
    if (poke_spare) begin
      reg_index  <= REG_SPARE;
      write_data <= psd_pkg::DELAY_BITS'($urandom());
      @(negedge clk);
    end
    write_en <= 1'b0;
  endtask

  function automatic logic [psd_pkg::DELAY_BITS-1:0] pick_delay();
    case ($urandom_range(0, 19))
      0, 1, 2:    return psd_pkg::DELAY_BITS'($urandom());
      3, 4, 5, 6: return psd_pkg::DELAY_BITS'($urandom_range(1, 1000));
      default:    return psd_pkg::DELAY_BITS'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [psd_pkg::DELAY_BITS-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return psd_pkg::DELAY_BITS'($urandom());
      1:       return psd_pkg::DELAY_BITS'(psd_pkg::GAIN_UNITY);
      2:       return '0;
      default: return psd_pkg::DELAY_BITS'($urandom_range(0, 300));
    endcase
  endfunction

  initial begin
    int phases;
    int count;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    write_en   = 1'b0;
    reg_index  = '0;
    write_data = '0;
    jitter     = 1'b0;
    hold_long  = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: long delay reads cleared lines, half wet mix.
    send_pair(psd_pkg::SAMPLE_MAX, psd_pkg::SAMPLE_MIN);
    send_pair(psd_pkg::SAMPLE_MIN, psd_pkg::SAMPLE_MAX);
    send_pair('0, '0);
    send_pair(smp(-1), smp(1));
    send_pair(psd_pkg::SAMPLE_MAX, psd_pkg::SAMPLE_MAX);
    send_pair(psd_pkg::SAMPLE_MIN, psd_pkg::SAMPLE_MIN);
    settle();

    // Delay of one with unity feedback and full wet: stored sums clamp.
    program_regs(16'd1, psd_pkg::DELAY_BITS'(psd_pkg::GAIN_UNITY),
                 psd_pkg::DELAY_BITS'(psd_pkg::GAIN_UNITY), 1'b1);
    jitter = 1'b1;
    repeat (3) send_pair(psd_pkg::SAMPLE_MAX, psd_pkg::SAMPLE_MAX);
    repeat (3) send_pair(psd_pkg::SAMPLE_MIN, psd_pkg::SAMPLE_MIN);
    send_pair(psd_pkg::SAMPLE_MAX, psd_pkg::SAMPLE_MIN);
    send_pair(smp(1), smp(-1));
    settle();

    // Zero delay reads a full line ago; oversized feedback saturates.
    program_regs('0, '1, '0, 1'b0);
    send_pair(psd_pkg::SAMPLE_MIN, psd_pkg::SAMPLE_MAX);
    send_pair(smp(-1), smp(-1));
    send_pair(psd_pkg::SAMPLE_MAX, smp(1));
    send_pair(smp(100), smp(-100));
    settle();

    // Largest delay, no feedback, oversized wet.
    program_regs('1, '0, '1, 1'b0);
    send_pair(psd_pkg::SAMPLE_MAX, psd_pkg::SAMPLE_MIN);
    send_pair(smp(-1), psd_pkg::SAMPLE_MAX);
    settle();

    // Short delay with feedback above unity and a tiny wet share.
    program_regs(16'd2, 16'd300, 16'd1, 1'b0);
    send_pair(psd_pkg::SAMPLE_MAX, psd_pkg::SAMPLE_MAX);
    send_pair(psd_pkg::SAMPLE_MIN, psd_pkg::SAMPLE_MAX);
    send_pair(psd_pkg::SAMPLE_MAX, psd_pkg::SAMPLE_MIN);
    settle();

    phases = 12;
    for (int p = 0; p < phases; p++) begin
      program_regs(pick_delay(), pick_gain(), pick_gain(), $urandom_range(0, 3) == 0);
      jitter = (p < phases - 3) && ($urandom_range(0, 3) != 0);
      // Long output hold-off while input keeps coming: the pipe fills up.
      if (p == 3) hold_long = 1'b1;
      count = $urandom_range(75, 95);
      repeat (count) send_pair(pick_sample(), pick_sample());
      settle();
    end

    repeat (12) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
